// ----- sv/assert_macros.svh -----
// assertion helpers for the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpcs assertion failed");

// next-cycle implication, checked outside reset
`define LPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpcs assertion failed");

`endif

// ----- sv/lpcs_pkg.sv -----
package lpcs_pkg;

	// panel geometry
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 128;

	// coordinate offset, all coordinate bytes modulo 256
	localparam logic [7:0] COORD_OFFSET = 8'h02;

	// results per item
	localparam int MAX_RESULTS = 6;
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// input kinds
	localparam logic [1:0] KIND_SCRIPT = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_AREA   = 2'd2;

	// script header tags, top two bits
	localparam logic [1:0] HDR_SKIP = 2'b00;
	localparam logic [1:0] HDR_CMD  = 2'b01;
	localparam logic [1:0] HDR_DATA = 2'b10;
	localparam logic [1:0] HDR_WAIT = 2'b11;

	// register indexes
	localparam logic [1:0] CFG_ROTATION = 2'd0;
	localparam logic [1:0] CFG_X_CMD    = 2'd1;
	localparam logic [1:0] CFG_Y_CMD    = 2'd2;

	// rotations
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;

	typedef enum logic [1:0] {
		ACT_CMD  = 2'd0,
		ACT_DATA = 2'd1,
		ACT_WAIT = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_CMD  = 2'd1,
		MODE_DATA = 2'd2
	} script_mode_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  script_byte;
		logic [15:0] pixel_value;
		logic [7:0]  x_start;
		logic [7:0]  y_start;
		logic [7:0]  x_end;
		logic [7:0]  y_end;
	} in_item_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] bus_byte;
		logic [5:0] wait_ms;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] rotation;
		logic [7:0] x_area_command;
		logic [7:0] y_area_command;
	} cfg_t;

	typedef struct packed {
		script_mode_t mode;
		logic [5:0]   run_left;
	} script_state_t;

endpackage

// ----- sv/lpcs_decode.sv -----
module lpcs_decode #(
	parameter int PANEL_WIDTH  = lpcs_pkg::PANEL_WIDTH,
	parameter int PANEL_HEIGHT = lpcs_pkg::PANEL_HEIGHT
) (
	input  lpcs_pkg::in_item_t      item,
	input  lpcs_pkg::cfg_t          cfg,
	input  lpcs_pkg::script_state_t state,
	output lpcs_pkg::out_item_t     results [lpcs_pkg::MAX_RESULTS],
	output logic [lpcs_pkg::CNT_W-1:0] count,
	output lpcs_pkg::script_state_t state_next
);
	import lpcs_pkg::*;

	// mirror bases: size - 1 plus the offset, modulo 256
	localparam logic [7:0] MIRROR_X = 8'(PANEL_WIDTH - 1) + COORD_OFFSET;
	localparam logic [7:0] MIRROR_Y = 8'(PANEL_HEIGHT - 1) + COORD_OFFSET;

	logic [7:0] a0, a1, b0, b1;
	logic [5:0] n;
	logic [5:0] run_dec;

	assign n       = item.script_byte[5:0];
	assign run_dec = state.run_left - 6'd1;

	// window coordinates per orientation
	always_comb begin
		case (cfg.rotation)
			ROT_0: begin
				a0 = MIRROR_X - item.x_end;
				a1 = MIRROR_X - item.x_start;
				b0 = item.y_start + COORD_OFFSET;
				b1 = item.y_end + COORD_OFFSET;
			end
			ROT_90: begin
				a0 = item.y_start + COORD_OFFSET;
				a1 = item.y_end + COORD_OFFSET;
				b0 = item.x_start + COORD_OFFSET;
				b1 = item.x_end + COORD_OFFSET;
			end
			ROT_180: begin
				a0 = item.x_start + COORD_OFFSET;
				a1 = item.x_end + COORD_OFFSET;
				b0 = MIRROR_Y - item.y_end;
				b1 = MIRROR_Y - item.y_start;
			end
			default: begin
				a0 = MIRROR_Y - item.y_end;
				a1 = MIRROR_Y - item.y_start;
				b0 = MIRROR_X - item.x_end;
				b1 = MIRROR_X - item.x_start;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			results[i] = '{action: ACT_CMD, bus_byte: 8'd0, wait_ms: 6'd0, last: 1'b0};
		end
		count      = '0;
		state_next = state;
		case (item.kind)
			KIND_SCRIPT: begin
				if (state.run_left != 6'd0 && state.mode != MODE_IDLE) begin
					// byte inside an open run
					results[0].action   = (state.mode == MODE_CMD) ? ACT_CMD : ACT_DATA;
					results[0].bus_byte = item.script_byte;
					results[0].last     = 1'b1;
					count               = CNT_W'(1);
					state_next.run_left = run_dec;
					if (run_dec == 6'd0) begin
						state_next.mode = MODE_IDLE;
					end
				end else begin
					case (item.script_byte[7:6])
						HDR_CMD, HDR_DATA: begin
							if (n != 6'd0) begin
								state_next.mode = (item.script_byte[7:6] == HDR_CMD) ?
									MODE_CMD : MODE_DATA;
								state_next.run_left = n;
							end else begin
								state_next.mode     = MODE_IDLE;
								state_next.run_left = 6'd0;
							end
						end
						HDR_WAIT: begin
							results[0].action  = ACT_WAIT;
							results[0].wait_ms = n;
							results[0].last    = 1'b1;
							count              = CNT_W'(1);
						end
						default: begin
							count = '0;
						end
					endcase
				end
			end
			KIND_PIXEL: begin
				results[0].action   = ACT_DATA;
				results[0].bus_byte = item.pixel_value[15:8];
				results[1].action   = ACT_DATA;
				results[1].bus_byte = item.pixel_value[7:0];
				results[1].last     = 1'b1;
				count               = CNT_W'(2);
			end
			KIND_AREA: begin
				results[0].bus_byte = cfg.x_area_command;
				results[1].bus_byte = a0;
				results[2].bus_byte = a1;
				results[3].bus_byte = cfg.y_area_command;
				results[4].bus_byte = b0;
				results[5].bus_byte = b1;
				results[5].last     = 1'b1;
				count               = CNT_W'(6);
			end
			default: begin
				count = '0;
			end
		endcase
	end

endmodule

// ----- sv/lcd_parallel_command_sequencer_core.sv -----
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    in_data  (lpcs_pkg::in_item_t)
// out       output     out_valid / out_stall  out_data (lpcs_pkg::out_item_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// one bus write or wait leaves per cycle through the output register unless
// out stalls; script bytes give at most one entry, pixels two, set-areas six;
// items with no result (headers, ignored bytes, unused kind) are not staged
// reset is asynchronous: script state idle, cfg zero, nothing in flight
// a stall on out holds the output register and the staged results; in stalls
// only while the staged results of the previous item are still being sent
`include "assert_macros.svh"

module lcd_parallel_command_sequencer_core #(
	parameter int PANEL_WIDTH  = lpcs_pkg::PANEL_WIDTH,
	parameter int PANEL_HEIGHT = lpcs_pkg::PANEL_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lpcs_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lpcs_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import lpcs_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// script run state
	script_state_t script_q;
	script_state_t script_next;

	// decoded results of the current item
	out_item_t        dec_results [MAX_RESULTS];
	logic [CNT_W-1:0] dec_count;

	// staged results waiting to be sent
	out_item_t        res_s1 [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_s1;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	logic in_accept;
	logic emit;
	logic last_entry;

	lpcs_decode #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_decode (
		.item       (in_data),
		.cfg        (cfg_q),
		.state      (script_q),
		.results    (dec_results),
		.count      (dec_count),
		.state_next (script_next)
	);

	// output register takes a new entry when empty or being drained
	assign emit       = valid_s1 && (!out_valid_q || !out_stall);
	assign last_entry = (CNT_W'(idx_q) == cnt_s1 - CNT_W'(1));

	// a new item may enter in the cycle the last staged entry moves out
	assign in_stall  = valid_s1 && !(emit && last_entry);
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTATION: cfg_q.rotation       <= cfg_data[1:0];
				CFG_X_CMD:    cfg_q.x_area_command <= cfg_data;
				CFG_Y_CMD:    cfg_q.y_area_command <= cfg_data;
				default:      cfg_q                <= cfg_q;
			endcase
		end
	end

	// script state advances on every accepted item; non-script kinds keep it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_q <= '{mode: MODE_IDLE, run_left: 6'd0};
		end else if (in_accept) begin
			script_q <= script_next;
		end
	end

	// staging control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (in_accept && dec_count != '0) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (emit && last_entry) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (emit) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// staged payload
	always_ff @(posedge clk) begin
		if (in_accept && dec_count != '0) begin
			res_s1 <= dec_results;
			cnt_s1 <= dec_count;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res_s1[idx_q];
		end
	end

	// send index stays inside the staged list
	`LPCS_ASSERT_NOW(a_idx_in_range, clk, arst_n, valid_s1, CNT_W'(idx_q) < cnt_s1)
	// an open run always owes bytes, an idle script owes none
	`LPCS_ASSERT_NOW(a_run_matches_mode, clk, arst_n, 1'b1,
		(script_q.mode == MODE_IDLE) == (script_q.run_left == 6'd0))
	// item with results starts its list from the first entry
	`LPCS_ASSERT_NEXT(a_stage_load, clk, arst_n, in_accept && dec_count != '0,
		valid_s1 && idx_q == '0)
	// last entry sent and nothing new taken empties the stage
	`LPCS_ASSERT_NEXT(a_stage_drain, clk, arst_n, emit && last_entry && !in_accept, !valid_s1)

endmodule
